// ----- sv/lsls_pkg.sv -----
// Shared widths, codes, transaction record and saturation helper of the light link solver.
package lsls_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VW        = 19;
  localparam int DW        = 32;
  localparam int TOLW      = 16;
  localparam int PRW       = VW + DW;
  localparam int TXW       = (((50 - FRAC_BITS) > 33) ? (50 - FRAC_BITS) : 33) + 1;
  localparam int NUMW      = TXW + 2;
  localparam int DVW       = NUMW + FRAC_BITS;
  localparam int DENW      = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;
  localparam int TW        = DVW + 1;
  localparam int LOW       = TW / 2;
  localparam int HIW       = TW - LOW;
  localparam int PW        = VW + TW;
  localparam int CW        = TXW + 3;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    CLS_ORIGIN, CLS_PAST, CLS_LIGHT, CLS_FUTURE, CLS_SPACE
  } cls_t;

  typedef enum logic [1:0] {
    LINK_NONE, LINK_ORIGIN, LINK_VALID
  } link_t;

  typedef enum logic [1:0] {
    REG_TRANSMIT_TIME, REG_SENDER_VELOCITY, REG_SENDER_INTERCEPT, REG_NULL_TOLERANCE
  } reg_index_t;

  typedef struct packed {
    logic signed [DW-1:0]   transmit_time;
    logic signed [VW-1:0]   sender_velocity;
    logic signed [DW-1:0]   sender_intercept;
    logic        [TOLW-1:0] null_tolerance;
  } cfg_t;

  typedef struct packed {
    logic                   mode;
    logic                   is_tx;
    cls_t                   cls;
    logic                   dir_x;
    logic signed [DW-1:0]   et;
    logic signed [DW-1:0]   ex;
    logic signed [VW-1:0]   ov;
    logic signed [DW-1:0]   oi;
    logic signed [DW-1:0]   tt;
    logic        [TOLW-1:0] tol;
    logic signed [TXW-1:0]  tx;
    logic signed [NUMW-1:0] num0;
    logic signed [NUMW-1:0] num1;
    logic signed [DENW-1:0] den0;
    logic signed [DENW-1:0] den1;
    logic                   skip0;
    logic                   skip1;
  } item_t;

  typedef struct packed {
    logic                 flag;
    logic signed [DW-1:0] value;
  } sat_t;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    if (x > MAX32) begin
      r.flag  = 1'b1;
      r.value = MAX32[DW-1:0];
    end else if (x < MIN32) begin
      r.flag  = 1'b1;
      r.value = MIN32[DW-1:0];
    end else begin
      r.flag  = 1'b0;
      r.value = x[DW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/light_signal_link_solver.sv -----
// Light signal link solver: takes one transaction per clock cycle while busy is low and
// returns one result per transaction, in order, marked by done for a single cycle. The
// pipelined radix-2 dividers solve both ray directions, one quotient bit per stage;
// times and positions are Q16.16. The receiver cannot stall, so results must be taken in
// the cycle they appear. busy rises only if the internal queue fills, which does not
// happen in normal operation.
module light_signal_link_solver import lsls_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode,
  input  logic signed [DW-1:0] event_time,
  input  logic signed [DW-1:0] event_x,
  input  logic signed [VW-1:0] obs_velocity,
  input  logic signed [DW-1:0] obs_intercept,
  input  logic                 is_transmitter,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [DW-1:0]        cfg_data,
  output logic                 done,
  output logic [2:0]           event_class,
  output logic [1:0]           link_state,
  output logic                 ray_direction,
  output logic signed [DW-1:0] receive_time,
  output logic signed [DW-1:0] receive_x,
  output logic                 saturated
);

  cfg_t  cfg;
  logic  accept, push, head_valid, full;
  item_t push_item, head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transmit_time    <= '0;
      cfg.sender_velocity  <= '0;
      cfg.sender_intercept <= '0;
      cfg.null_tolerance   <= TOLW'(1);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_TRANSMIT_TIME:    cfg.transmit_time    <= cfg_data;
        REG_SENDER_VELOCITY:  cfg.sender_velocity  <= cfg_data[VW-1:0];
        REG_SENDER_INTERCEPT: cfg.sender_intercept <= cfg_data;
        REG_NULL_TOLERANCE:   cfg.null_tolerance   <= cfg_data[TOLW-1:0];
      endcase
    end
  end

  assign busy   = full;
  assign accept = start && !busy;

  lsls_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .mode(mode),
    .event_time(event_time), .event_x(event_x), .obs_velocity(obs_velocity),
    .obs_intercept(obs_intercept), .is_transmitter(is_transmitter), .cfg(cfg),
    .push(push), .push_item(push_item)
  );

  lsls_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .pop(head_valid),
    .head_valid(head_valid), .head_item(head_item), .full(full)
  );

  lsls_back u_back (
    .clk(clk), .rst(rst), .in_valid(head_valid), .item(head_item), .done(done),
    .event_class(event_class), .link_state(link_state), .ray_direction(ray_direction),
    .receive_time(receive_time), .receive_x(receive_x), .saturated(saturated)
  );

endmodule

// ----- sv/lsls_front.sv -----
// Front end: accepts transactions, computes the emission point and classifies the event.
module lsls_front import lsls_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 mode,
  input  logic signed [DW-1:0] event_time,
  input  logic signed [DW-1:0] event_x,
  input  logic signed [VW-1:0] obs_velocity,
  input  logic signed [DW-1:0] obs_intercept,
  input  logic                 is_transmitter,
  input  cfg_t                 cfg,
  output logic                 push,
  output item_t                push_item
);

  logic                  v1, v2;
  logic                  mode1, istx1, mode2, istx2;
  logic signed [DW-1:0]  et1, ex1, oi1, et2, ex2, oi2;
  logic signed [VW-1:0]  ov1, ov2;
  cfg_t                  cfg1, cfg2;
  logic signed [PRW-1:0] prod, prod1;
  logic signed [PRW:0]   rnd;
  logic signed [PRW:0]   shifted;
  logic signed [TXW-1:0] tx_next, tx2;

  assign prod = PRW'(cfg.sender_velocity) * PRW'(cfg.transmit_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    mode1 <= mode;
    istx1 <= is_transmitter;
    et1   <= event_time;
    ex1   <= event_x;
    ov1   <= obs_velocity;
    oi1   <= obs_intercept;
    cfg1  <= cfg;
    prod1 <= prod;
  end

  // Product rounded to nearest with ties toward positive infinity.
  assign rnd     = (PRW+1)'(prod1) + (PRW+1)'(HALF);
  assign shifted = rnd >>> FRAC_BITS;
  assign tx_next = TXW'(shifted) + TXW'(cfg1.sender_intercept);

  always_ff @(posedge clk) begin
    mode2 <= mode1;
    istx2 <= istx1;
    et2   <= et1;
    ex2   <= ex1;
    ov2   <= ov1;
    oi2   <= oi1;
    cfg2  <= cfg1;
    tx2   <= tx_next;
  end

  logic signed [CW-1:0]   dt, dx, adt, adx, diff, adiff, tolc;
  logic signed [DENW-1:0] den0, den1, aden0, aden1, told;
  cls_t                   cls;

  assign tolc  = CW'($signed({1'b0, cfg2.null_tolerance}));
  assign told  = DENW'($signed({1'b0, cfg2.null_tolerance}));
  assign dt    = CW'(et2) - CW'(cfg2.transmit_time);
  assign dx    = CW'(ex2) - CW'(tx2);
  assign adt   = dt[CW-1] ? -dt : dt;
  assign adx   = dx[CW-1] ? -dx : dx;
  assign diff  = dt - adx;
  assign adiff = diff[CW-1] ? -diff : diff;

  always_comb begin
    priority if (adt <= tolc && adx <= tolc) cls = CLS_ORIGIN;
    else if (dt < -tolc)                     cls = CLS_PAST;
    else if (adiff <= tolc && dt > 0)        cls = CLS_LIGHT;
    else if (dt > adx)                       cls = CLS_FUTURE;
    else                                     cls = CLS_SPACE;
  end

  assign den0  = DENW'(ONE) - DENW'(ov2);
  assign den1  = -DENW'(ONE) - DENW'(ov2);
  assign aden0 = den0[DENW-1] ? -den0 : den0;
  assign aden1 = den1[DENW-1] ? -den1 : den1;

  always_comb begin
    push_item.mode  = mode2;
    push_item.is_tx = istx2;
    push_item.cls   = cls;
    push_item.dir_x = dx[CW-1];
    push_item.et    = et2;
    push_item.ex    = ex2;
    push_item.ov    = ov2;
    push_item.oi    = oi2;
    push_item.tt    = cfg2.transmit_time;
    push_item.tol   = cfg2.null_tolerance;
    push_item.tx    = tx2;
    push_item.num0  = NUMW'(oi2) - NUMW'(tx2) + NUMW'(cfg2.transmit_time);
    push_item.num1  = NUMW'(oi2) - NUMW'(tx2) - NUMW'(cfg2.transmit_time);
    push_item.den0  = den0;
    push_item.den1  = den1;
    push_item.skip0 = aden0 <= told;
    push_item.skip1 = aden1 <= told;
  end

  assign push = v2;

endmodule

// ----- sv/lsls_queue.sv -----
// Two-entry queue between the front end and the back end.
module lsls_queue import lsls_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item,
  output logic  full
);

  item_t      mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

  assign head_valid = count != 2'd0;
  assign head_item  = mem[rptr];
  assign full       = count == 2'd2;

endmodule

// ----- sv/lsls_div.sv -----
// Pipelined radix-2 restoring divider, one quotient bit per stage.
module lsls_div import lsls_pkg::*; (
  input  logic            clk,
  input  logic [DVW-1:0]  dividend,
  input  logic [DENW-1:0] divisor,
  output logic [DVW-1:0]  quotient
);

  logic [DENW-1:0] rem [DVW];
  logic [DVW-1:0]  quo [DVW];
  logic [DVW-1:0]  dvd [DVW-1];
  logic [DENW-1:0] dsr [DVW-1];

  for (genvar s = 0; s < DVW; s++) begin : g_stage
    logic [DENW-1:0] rem_in, dsr_in;
    logic [DVW-1:0]  quo_in, dvd_in;
    logic [DENW:0]   trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvd_in = dividend;
      assign dsr_in = divisor;
    end else begin : g_next
      assign rem_in = rem[s-1];
      assign quo_in = quo[s-1];
      assign dvd_in = dvd[s-1];
      assign dsr_in = dsr[s-1];
    end

    assign trial = {rem_in, dvd_in[DVW-1]};
    assign ge    = trial >= {1'b0, dsr_in};

    always_ff @(posedge clk) begin
      rem[s] <= ge ? DENW'(trial - {1'b0, dsr_in}) : DENW'(trial);
      quo[s] <= {quo_in[DVW-2:0], ge};
    end

    if (s < DVW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        dvd[s] <= dvd_in << 1;
        dsr[s] <= dsr_in;
      end
    end
  end

  assign quotient = quo[DVW-1];

endmodule

// ----- sv/lsls_back.sv -----
// Back end: solves both ray directions, picks the earliest reception and formats results.
module lsls_back import lsls_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  item_t                item,
  output logic                 done,
  output logic [2:0]           event_class,
  output logic [1:0]           link_state,
  output logic                 ray_direction,
  output logic signed [DW-1:0] receive_time,
  output logic signed [DW-1:0] receive_x,
  output logic                 saturated
);

  logic [NUMW-1:0] mag0, mag1;
  logic [DENW-1:0] dmag0, dmag1;
  logic [DVW-1:0]  q0, q1;

  assign mag0  = item.num0[NUMW-1] ? NUMW'(-item.num0) : NUMW'(item.num0);
  assign mag1  = item.num1[NUMW-1] ? NUMW'(-item.num1) : NUMW'(item.num1);
  assign dmag0 = item.den0[DENW-1] ? DENW'(-item.den0) : DENW'(item.den0);
  assign dmag1 = item.den1[DENW-1] ? DENW'(-item.den1) : DENW'(item.den1);

  lsls_div u_div0 (
    .clk(clk), .dividend({mag0, {FRAC_BITS{1'b0}}}), .divisor(dmag0), .quotient(q0)
  );
  lsls_div u_div1 (
    .clk(clk), .dividend({mag1, {FRAC_BITS{1'b0}}}), .divisor(dmag1), .quotient(q1)
  );

  // The transaction record rides alongside the divider stages.
  item_t dl_item [DVW];
  logic  dl_v    [DVW];
  logic  dl_n0   [DVW];
  logic  dl_n1   [DVW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DVW; i++) dl_v[i] <= 1'b0;
    end else begin
      dl_v[0] <= in_valid;
      for (int i = 1; i < DVW; i++) dl_v[i] <= dl_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dl_item[0] <= item;
    dl_n0[0]   <= item.num0[NUMW-1] ^ item.den0[DENW-1];
    dl_n1[0]   <= item.num1[NUMW-1] ^ item.den1[DENW-1];
    for (int i = 1; i < DVW; i++) begin
      dl_item[i] <= dl_item[i-1];
      dl_n0[i]   <= dl_n0[i-1];
      dl_n1[i]   <= dl_n1[i-1];
    end
  end

  item_t               rd;
  logic signed [TW-1:0] t0, t1, thr, best_next;
  logic                 ok0, ok1, pick1;

  assign rd    = dl_item[DVW-1];
  assign t0    = dl_n0[DVW-1] ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
  assign t1    = dl_n1[DVW-1] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
  assign thr   = TW'(rd.tt) + TW'($signed({1'b0, rd.tol}));
  assign ok0   = !rd.skip0 && (t0 > thr);
  assign ok1   = !rd.skip1 && (t1 > thr);
  // On equal times the positive direction is kept.
  assign pick1 = ok1 && (!ok0 || (t1 < t0));
  assign best_next = pick1 ? t1 : t0;

  logic                 v1, v2, v3;
  item_t                it1, it2, it3;
  logic signed [TW-1:0] best1, best2, best3;
  logic                 dir1, dir2, dir3, found1, found2, found3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= dl_v[DVW-1];
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    it1    <= rd;
    best1  <= best_next;
    dir1   <= pick1;
    found1 <= ok0 | ok1;
  end

  // Reception position: the wide product is split into two partial products.
  logic        [LOW-1:0]    lo;
  logic signed [HIW-1:0]    hi;
  logic signed [VW+LOW:0]   pl, pl2;
  logic signed [VW+HIW-1:0] ph, ph2;

  assign lo = best1[LOW-1:0];
  assign hi = best1[TW-1:LOW];
  assign pl = (VW+LOW+1)'(it1.ov) * (VW+LOW+1)'($signed({1'b0, lo}));
  assign ph = (VW+HIW)'(it1.ov) * (VW+HIW)'(hi);

  always_ff @(posedge clk) begin
    it2    <= it1;
    best2  <= best1;
    dir2   <= dir1;
    found2 <= found1;
    pl2    <= pl;
    ph2    <= ph;
  end

  logic signed [PW-1:0] full_prod, rnd, mq;
  logic signed [63:0]   rxw_next, rxw3;

  assign full_prod = (PW'(ph2) <<< LOW) + PW'(pl2);
  assign rnd       = full_prod + PW'(HALF);
  assign mq        = rnd >>> FRAC_BITS;
  assign rxw_next  = 64'(mq) + 64'(it2.oi);

  always_ff @(posedge clk) begin
    it3    <= it2;
    best3  <= best2;
    dir3   <= dir2;
    found3 <= found2;
    rxw3   <= rxw_next;
  end

  sat_t st_tx, st_t, st_x;

  assign st_tx = sat32(64'(it3.tx));
  assign st_t  = sat32(64'(best3));
  assign st_x  = sat32(rxw3);

  always_ff @(posedge clk) begin
    priority if (!it3.mode) begin
      event_class   <= it3.cls;
      link_state    <= LINK_NONE;
      ray_direction <= it3.dir_x;
      receive_time  <= it3.et;
      receive_x     <= it3.ex;
      saturated     <= 1'b0;
    end else if (it3.is_tx) begin
      event_class   <= CLS_ORIGIN;
      link_state    <= LINK_ORIGIN;
      ray_direction <= 1'b0;
      receive_time  <= it3.tt;
      receive_x     <= st_tx.value;
      saturated     <= st_tx.flag;
    end else if (found3) begin
      event_class   <= CLS_ORIGIN;
      link_state    <= LINK_VALID;
      ray_direction <= dir3;
      receive_time  <= st_t.value;
      receive_x     <= st_x.value;
      saturated     <= st_t.flag | st_x.flag;
    end else begin
      event_class   <= CLS_ORIGIN;
      link_state    <= LINK_NONE;
      ray_direction <= 1'b0;
      receive_time  <= '0;
      receive_x     <= '0;
      saturated     <= 1'b0;
    end
  end

endmodule

// ----- verif/light_signal_link_solver_tb.sv -----
// Self-checking testbench for the light signal link solver: directed and random transactions.
`timescale 1ns / 100ps

module light_signal_link_solver_tb;
  import lsls_pkg::*;

  typedef struct {
    cls_t        cls;
    link_t       link;
    logic        dir;
    logic [31:0] rtime;
    logic [31:0] rx;
    logic        sat;
  } link_result_t;

  class link_scoreboard;
    longint tt, sv, si, tol;
    link_result_t pending[$];
    int errors;
    int results;

    function new();
      tt = 0; sv = 0; si = 0; tol = 1; errors = 0; results = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [31:0] d);
      case (idx)
        REG_TRANSMIT_TIME:    tt = longint'($signed(d));
        REG_SENDER_VELOCITY:  sv = longint'($signed(d[VW-1:0]));
        REG_SENDER_INTERCEPT: si = longint'($signed(d));
        REG_NULL_TOLERANCE:   tol = longint'(d[TOLW-1:0]);
        default: ;
      endcase
    endfunction

    // Rounded Q16.16 product, ties toward plus infinity.
    function longint qmul(longint v, longint t);
      longint hi, lo;
      hi = t >>> FRAC_BITS;
      lo = t - (hi <<< FRAC_BITS);
      return v * hi + ((v * lo + HALF) >>> FRAC_BITS);
    endfunction

    function longint emit_x();
      return si + qmul(sv, tt);
    endfunction

    function logic [31:0] clip(longint x, ref logic f);
      if (x > 64'sd2147483647) begin
        f = 1'b1;
        return 32'h7fffffff;
      end
      if (x < -64'sd2147483648) begin
        f = 1'b1;
        return 32'h80000000;
      end
      return x[31:0];
    endfunction

    function void note(logic m, logic [31:0] et, logic [31:0] ex, logic [VW-1:0] ov,
                       logic [31:0] oi, logic istx);
      link_result_t r;
      longint t_e, x_e, v_o, i_o, tx, dt, dx, adx, den, num, t, best, s;
      bit found;
      t_e = longint'($signed(et));
      x_e = longint'($signed(ex));
      v_o = longint'($signed(ov));
      i_o = longint'($signed(oi));
      tx = emit_x();
      r.cls = CLS_ORIGIN; r.link = LINK_NONE; r.dir = 0; r.rtime = 0; r.rx = 0; r.sat = 0;
      if (!m) begin
        dt = t_e - tt;
        dx = x_e - tx;
        adx = dx < 0 ? -dx : dx;
        if ((dt < 0 ? -dt : dt) <= tol && adx <= tol) r.cls = CLS_ORIGIN;
        else if (dt < -tol) r.cls = CLS_PAST;
        else if (((dt - adx) < 0 ? adx - dt : dt - adx) <= tol && dt > 0) r.cls = CLS_LIGHT;
        else if (dt > adx) r.cls = CLS_FUTURE;
        else r.cls = CLS_SPACE;
        r.dir = dx < 0;
        r.rtime = et;
        r.rx = ex;
      end else if (istx) begin
        r.link = LINK_ORIGIN;
        r.rtime = tt[31:0];
        r.rx = clip(tx, r.sat);
      end else begin
        found = 0;
        best = 0;
        for (int d = 0; d < 2; d++) begin
          s = d == 0 ? ONE : -ONE;
          den = s - v_o;
          if ((den < 0 ? -den : den) <= tol) continue;
          num = i_o - tx + (d == 0 ? tt : -tt);
          t = (num <<< FRAC_BITS) / den;
          if (t <= tt + tol) continue;
          if (!found || t < best) begin
            found = 1;
            best = t;
            r.dir = d[0];
          end
        end
        if (found) begin
          r.link = LINK_VALID;
          r.rtime = clip(best, r.sat);
          r.rx = clip(i_o + qmul(v_o, best), r.sat);
        end else begin
          r.dir = 0;
        end
      end
      pending.push_back(r);
    endfunction

    function void check(logic [2:0] c, logic [1:0] l, logic d, logic [31:0] rt,
                        logic [31:0] rx, logic s);
      link_result_t e;
      results++;
      if (pending.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (c !== e.cls) begin
        $error("event_class: expected %0d, got %0d", e.cls, c); errors++;
      end
      if (l !== e.link) begin
        $error("link_state: expected %0d, got %0d", e.link, l); errors++;
      end
      if (d !== e.dir) begin
        $error("ray_direction: expected %0d, got %0d", e.dir, d); errors++;
      end
      if (rt !== e.rtime) begin
        $error("receive_time: expected %h, got %h", e.rtime, rt); errors++;
      end
      if (rx !== e.rx) begin
        $error("receive_x: expected %h, got %h", e.rx, rx); errors++;
      end
      if (s !== e.sat) begin
        $error("saturated: expected %0d, got %0d", e.sat, s); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done;
  logic mode = 0;
  logic signed [DW-1:0] event_time = 0, event_x = 0, obs_intercept = 0;
  logic signed [VW-1:0] obs_velocity = 0;
  logic is_transmitter = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [DW-1:0] cfg_data = 0;
  logic [2:0] event_class;
  logic [1:0] link_state;
  logic ray_direction, saturated;
  logic signed [DW-1:0] receive_time, receive_x;

  link_scoreboard links = new();
  int cycles = 0;
  int gap_mode = 0;

  light_signal_link_solver u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .event_time(event_time), .event_x(event_x), .obs_velocity(obs_velocity),
    .obs_intercept(obs_intercept), .is_transmitter(is_transmitter),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .event_class(event_class), .link_state(link_state), .ray_direction(ray_direction),
    .receive_time(receive_time), .receive_x(receive_x), .saturated(saturated)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst) begin
      if (cfg_we) links.write_reg(reg_index_t'(cfg_index), cfg_data);
      if (start && !busy)
        links.note(mode, event_time, event_x, obs_velocity, obs_intercept, is_transmitter);
      if (done)
        links.check(event_class, link_state, ray_direction, receive_time, receive_x,
                    saturated);
    end
  end

  task automatic write_reg(reg_index_t idx, logic [31:0] d);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Stop sending and let every outstanding transaction come back, plus pipeline slack.
  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (links.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic send(logic m, logic [31:0] et, logic [31:0] ex, logic [VW-1:0] ov,
                      logic [31:0] oi, logic istx);
    int g;
    @(negedge clk);
    start <= 1;
    mode <= m;
    event_time <= et;
    event_x <= ex;
    obs_velocity <= ov;
    obs_intercept <= oi;
    is_transmitter <= istx;
    do @(posedge clk); while (busy);
    g = 0;
    if (gap_mode != 0) begin
      g = $urandom_range(0, 99);
      g = g < 55 ? 0 : g < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
    repeat (g) begin
      @(negedge clk);
      start <= 0;
    end
  endtask

  function automatic logic [31:0] any_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'h7fffffff;
      3: return 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  function automatic logic [VW-1:0] any_velocity();
    int w;
    w = links.tol > 60000 ? 4 : int'(links.tol) + 4;
    case ($urandom_range(0, 5))
      0: return VW'(65536 + $signed($urandom_range(0, 2 * w)) - w);
      1: return VW'(-65536 + $signed($urandom_range(0, 2 * w)) - w);
      2: return $urandom_range(0, 1) ? VW'(131072) : VW'(-131072);
      default: return VW'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  task automatic random_item();
    longint d, x0;
    int j;
    logic [31:0] et, ex;
    if ($urandom_range(0, 1)) begin
      et = any_value();
      ex = any_value();
      // Most events are placed on or near the light cone of the emission point.
      if ($urandom_range(0, 3) != 0) begin
        d = $urandom_range(0, 1) ? longint'($urandom_range(0, 65536)) :
                                   longint'($urandom_range(0, 1 << 30));
        j = $signed($urandom_range(0, 8)) - 4;
        x0 = links.emit_x();
        et = 32'(links.tt + d + ($urandom_range(0, 1) ? j : 0));
        ex = 32'(x0 + ($urandom_range(0, 1) ? d : -d) + j);
      end
      send(0, et, ex, any_velocity(), any_value(), 1'($urandom_range(0, 1)));
    end else begin
      send(1, any_value(), any_value(), any_velocity(), any_value(),
           $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic directed_items();
    logic [31:0] tt, tx;
    tt = 32'(links.tt);
    tx = 32'(links.emit_x());
    send(0, tt, tx, 0, 0, 0);
    send(0, tt + 1, tx - 1, 0, 0, 1);
    send(0, tt - 65536, tx, 0, 0, 0);
    send(0, tt + 65536, tx + 65536, 0, 0, 0);
    send(0, tt + 65536, tx - 65536, 0, 0, 0);
    send(0, tt + 131072, tx + 100, 0, 0, 0);
    send(0, tt + 100, tx - 131072, 0, 0, 0);
    send(0, 32'h7fffffff, 32'h80000000, 0, 0, 0);
    send(0, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    send(1, 0, 0, 0, 0, 1);
    send(1, 0, 0, 0, 32'h00050000, 0);
    send(1, 0, 0, 0, 32'hfffb0000, 0);
    send(1, 0, 0, VW'(65536), 32'h00050000, 0);
    send(1, 0, 0, VW'(-65536), 32'hfffb0000, 0);
    send(1, 0, 0, VW'(131072), 32'h00030000, 0);
    send(1, 0, 0, VW'(-131072), 32'h00030000, 0);
    send(1, 0, 0, VW'(65535), 32'h7fffffff, 0);
    send(1, 0, 0, VW'(-65535), 32'h80000000, 0);
    send(1, 0, 0, VW'(65000), 32'h80000000, 0);
    send(1, 32'hffffffff, 32'hffffffff, VW'(-1), 32'h00000001, 0);
  endtask

  initial begin
    int n_phase;
    repeat (5) @(negedge clk);
    rst <= 0;
    directed_items();
    drain();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          write_reg(REG_TRANSMIT_TIME, 0); write_reg(REG_SENDER_VELOCITY, 0);
          write_reg(REG_SENDER_INTERCEPT, 0); write_reg(REG_NULL_TOLERANCE, 0);
        end
        1: begin
          write_reg(REG_TRANSMIT_TIME, 32'h7fffffff);
          write_reg(REG_SENDER_VELOCITY, 32'(131072));
          write_reg(REG_SENDER_INTERCEPT, 32'h80000000);
          write_reg(REG_NULL_TOLERANCE, 65535);
        end
        2: begin
          write_reg(REG_TRANSMIT_TIME, 32'h80000000);
          write_reg(REG_SENDER_VELOCITY, 32'(-131072));
          write_reg(REG_SENDER_INTERCEPT, 32'h7fffffff);
          write_reg(REG_NULL_TOLERANCE, 0);
        end
        default: begin
          write_reg(REG_TRANSMIT_TIME, 32'($signed($urandom_range(0, 2097152)) - 1048576));
          write_reg(REG_SENDER_VELOCITY, 32'($signed($urandom_range(0, 262144)) - 131072));
          write_reg(REG_SENDER_INTERCEPT, any_value());
          write_reg(REG_NULL_TOLERANCE, $urandom_range(0, 1) ? $urandom_range(0, 16) :
                                                               $urandom_range(0, 65535));
        end
      endcase
      if (p == 3) directed_items();
      n_phase = 135;
      for (int i = 0; i < n_phase; i++) begin
        if (i % 45 == 0) gap_mode = $urandom_range(0, 2);
        random_item();
      end
      drain();
    end
    $display("Checked %0d results over directed cases and 8 register settings,", links.results);
    $display("covering classification, sender and observer link solving.");
    if (links.errors == 0 && links.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/lsls_pkg.sv
sv/lsls_front.sv
sv/lsls_queue.sv
sv/lsls_div.sv
sv/lsls_back.sv
sv/light_signal_link_solver.sv
verif/light_signal_link_solver_tb.sv
